// ===== rtl/tds_pkg.sv =====
`default_nettype none

package tds_pkg;

  localparam int VTX_W = 6;   // vertex index / endpoint width
  localparam int NUM_W = 7;   // vertex count width
  localparam int CNT_W = 6;   // descendant count width (wraps)
  localparam int SUM_W = 11;  // distance sum width (wraps)

  // One word of the tree memory: parent link plus the two accumulators.
  typedef struct packed {
    logic [VTX_W-1:0] parent;
    logic [CNT_W-1:0] desc;
    logic [SUM_W-1:0] down;
  } tds_entry_t;

  localparam int ENTRY_W = $bits(tds_entry_t);

  // Sequencer state codes
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_UA   = 3'd2;
  localparam logic [2:0] S_UB   = 3'd3;
  localparam logic [2:0] S_UC   = 3'd4;
  localparam logic [2:0] S_DA   = 3'd5;
  localparam logic [2:0] S_DB   = 3'd6;
  localparam logic [2:0] S_DC   = 3'd7;

endpackage

`default_nettype wire

// ===== rtl/tds_in_if.sv =====
`default_nettype none

interface tds_in_if;
  import tds_pkg::*;

  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] vertex_count;
  logic [VTX_W-1:0] first_vertex;
  logic [VTX_W-1:0] second_vertex;
  logic             edge_valid;
  logic             last_edge;

  modport source (
    output valid, vertex_count, first_vertex, second_vertex, edge_valid, last_edge,
    input  ready
  );

  modport sink (
    input  valid, vertex_count, first_vertex, second_vertex, edge_valid, last_edge,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/tds_out_if.sv =====
`default_nettype none

interface tds_out_if;
  import tds_pkg::*;

  logic             valid;
  logic             ready;
  logic [VTX_W-1:0] vertex_index;
  logic [SUM_W-1:0] distance_sum;
  logic             last_result;

  modport source (
    output valid, vertex_index, distance_sum, last_result,
    input  ready
  );

  modport sink (
    input  valid, vertex_index, distance_sum, last_result,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/tds_ram.sv =====
`default_nettype none

module tds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/tds_seq.sv =====
`default_nettype none

module tds_seq #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  tds_in_if.sink                 in_chan,
  tds_out_if.source              out_chan,
  // tree memory
  output logic                   tree_we,
  output logic [$clog2(MAX_VERTICES)-1:0] tree_waddr,
  output tds_pkg::tds_entry_t    tree_wdata,
  output logic [$clog2(MAX_VERTICES)-1:0] tree_raddr,
  input  wire tds_pkg::tds_entry_t tree_rdata,
  // rerooted totals memory
  output logic                   tot_we,
  output logic [$clog2(MAX_VERTICES)-1:0] tot_waddr,
  output logic [tds_pkg::SUM_W-1:0] tot_wdata,
  output logic [$clog2(MAX_VERTICES)-1:0] tot_raddr,
  input  wire logic [tds_pkg::SUM_W-1:0] tot_rdata
);
  import tds_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    i_r, i_nxt;
  logic [NUM_W-1:0] n_r, n_nxt;
  logic [AW-1:0]    last_idx_r, last_idx_nxt;
  tds_entry_t       ent_r, ent_nxt;

  logic             out_valid_r;
  logic [VTX_W-1:0] out_index_r;
  logic [SUM_W-1:0] out_sum_r;
  logic             out_last_r;

  logic             in_fire;
  logic             out_slot;
  logic             out_load;
  logic [NUM_W-1:0] n_eff;
  logic             edge_ok;
  logic [VTX_W-1:0] child;
  logic [VTX_W-1:0] par;
  logic [SUM_W-1:0] total;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_slot      = !out_valid_r || out_chan.ready;
  assign out_load      = (state_r == S_DC) && out_slot;

  // Clamp the vertex count into 1..MAX_VERTICES.
  always_comb begin
    if (in_chan.vertex_count == '0) begin
      n_eff = NUM_W'(1);
    end else if (in_chan.vertex_count > NUM_W'(MAX_VERTICES)) begin
      n_eff = NUM_W'(MAX_VERTICES);
    end else begin
      n_eff = in_chan.vertex_count;
    end
  end

  assign edge_ok = in_chan.edge_valid
                && (in_chan.first_vertex != in_chan.second_vertex)
                && ({1'b0, in_chan.first_vertex} < n_eff)
                && ({1'b0, in_chan.second_vertex} < n_eff);
  assign child = (in_chan.first_vertex > in_chan.second_vertex) ?
                 in_chan.first_vertex : in_chan.second_vertex;
  assign par   = (in_chan.first_vertex > in_chan.second_vertex) ?
                 in_chan.second_vertex : in_chan.first_vertex;

  // Root total is its down sum plus its descendant count; others reroot from the parent.
  always_comb begin
    if (i_r == '0) begin
      total = ent_r.down + SUM_W'(ent_r.desc);
    end else begin
      total = tot_rdata + SUM_W'(n_r) - SUM_W'({ent_r.desc, 1'b0}) - SUM_W'(2);
    end
  end

  assign tot_raddr = (state_r == S_DB) ? tree_rdata.parent[AW-1:0] : ent_r.parent[AW-1:0];
  assign tot_we    = out_load;
  assign tot_waddr = i_r;
  assign tot_wdata = total;

  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    n_nxt        = n_r;
    last_idx_nxt = last_idx_r;
    ent_nxt      = ent_r;
    tree_we      = 1'b0;
    tree_waddr   = i_r;
    tree_wdata   = '0;
    tree_raddr   = i_r;
    case (state_r)
      S_CLR: begin
        tree_we = 1'b1;
        i_nxt   = i_r + AW'(1);
        if (i_r == AW'(MAX_VERTICES - 1)) begin
          i_nxt     = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (edge_ok) begin
            tree_we           = 1'b1;
            tree_waddr        = child[AW-1:0];
            tree_wdata.parent = par;
          end
          if (in_chan.last_edge) begin
            n_nxt        = n_eff;
            last_idx_nxt = AW'(n_eff - NUM_W'(1));
            i_nxt        = AW'(n_eff - NUM_W'(1));
            state_nxt    = S_UA;
          end
        end
      end
      S_UA: begin
        state_nxt = S_UB;
      end
      S_UB: begin
        ent_nxt    = tree_rdata;
        tree_raddr = tree_rdata.parent[AW-1:0];
        state_nxt  = (i_r == '0) ? S_DA : S_UC;
      end
      S_UC: begin
        // Push finished vertex into its parent.
        tree_we           = 1'b1;
        tree_waddr        = ent_r.parent[AW-1:0];
        tree_wdata.parent = tree_rdata.parent;
        tree_wdata.desc   = tree_rdata.desc + ent_r.desc + CNT_W'(1);
        tree_wdata.down   = tree_rdata.down + ent_r.down + SUM_W'(ent_r.desc);
        i_nxt             = i_r - AW'(1);
        state_nxt         = S_UA;
      end
      S_DA: begin
        state_nxt = S_DB;
      end
      S_DB: begin
        ent_nxt   = tree_rdata;
        state_nxt = S_DC;
      end
      S_DC: begin
        if (out_slot) begin
          // Clear accumulators for the next tree, keep the parent link.
          tree_we           = 1'b1;
          tree_wdata.parent = ent_r.parent;
          if (i_r == last_idx_r) begin
            i_nxt     = '0;
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + AW'(1);
            state_nxt = S_DA;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    last_idx_r <= last_idx_nxt;
    ent_r      <= ent_nxt;
    if (out_load) begin
      out_index_r <= VTX_W'(i_r);
      out_sum_r   <= total;
      out_last_r  <= (i_r == last_idx_r);
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.vertex_index = out_index_r;
  assign out_chan.distance_sum = out_sum_r;
  assign out_chan.last_result  = out_last_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_CLR) |-> (NUM_W'(i_r) < n_r))
    else $error("vertex counter outside the tree");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DC))
    else $error("result appeared outside the emit step");

  a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_chan.ready && !out_last_r) |=>
      (!out_valid_r || out_index_r == VTX_W'($past(out_index_r) + VTX_W'(1))))
    else $error("results out of vertex order");

  a_no_input_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_chan.last_edge) |=> (state_r == S_UA && !in_chan.ready))
    else $error("last item did not start the accumulate pass");

endmodule

`default_nettype wire

// ===== rtl/tree_distance_sums.sv =====
`default_nettype none

// Channel   Dir  Payload                                              Transfer
// in_chan   in   vertex_count, first_vertex, second_vertex,          valid && ready
//                edge_valid, last_edge
// out_chan  out  vertex_index, distance_sum, last_result             valid && ready
//
// An edge item that passes the edge checks writes one word of the tree
// memory. The last item starts two passes over the tree memory (single
// read port, registered read): one from the highest index down that pushes
// each non-root vertex into its parent, then one from index 0 up that
// reroots each vertex and emits its result, before the next item is taken.
// After reset a clearing pass zeroes every word of the tree memory;
// in_chan.ready stays low until it ends. Reset is synchronous, active low.
// A stalled output holds the rerooting pass; no result is dropped.

module tree_distance_sums #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tds_in_if.sink    in_chan,
  tds_out_if.source out_chan
);
  import tds_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);

  // Tree memory: parent link, descendant count, downward distance sum.
  logic             tree_we;
  logic [AW-1:0]    tree_waddr;
  tds_entry_t       tree_wdata;
  logic [AW-1:0]    tree_raddr;
  tds_entry_t       tree_rdata;

  // Totals memory: rerooted distance sum of each vertex, read by children.
  logic             tot_we;
  logic [AW-1:0]    tot_waddr;
  logic [SUM_W-1:0] tot_wdata;
  logic [AW-1:0]    tot_raddr;
  logic [SUM_W-1:0] tot_rdata;

  tds_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_VERTICES)
  ) u_tree_ram (
    .clk   (clk),
    .we    (tree_we),
    .waddr (tree_waddr),
    .wdata (tree_wdata),
    .raddr (tree_raddr),
    .rdata (tree_rdata)
  );

  tds_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_VERTICES)
  ) u_tot_ram (
    .clk   (clk),
    .we    (tot_we),
    .waddr (tot_waddr),
    .wdata (tot_wdata),
    .raddr (tot_raddr),
    .rdata (tot_rdata)
  );

  // Sequencer: edge loading, both passes and the output register.
  tds_seq #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .tree_we    (tree_we),
    .tree_waddr (tree_waddr),
    .tree_wdata (tree_wdata),
    .tree_raddr (tree_raddr),
    .tree_rdata (tree_rdata),
    .tot_we     (tot_we),
    .tot_waddr  (tot_waddr),
    .tot_wdata  (tot_wdata),
    .tot_raddr  (tot_raddr),
    .tot_rdata  (tot_rdata)
  );

endmodule

`default_nettype wire
